/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Check that a consequent holds in the cycle after its antecedent
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/i2cits_pkg.sv */
// ----------------------------------------------------------------------------
// I2C interrupt transfer sequencer package
// Types, codes and helpers shared by the sequencer modules.
// ----------------------------------------------------------------------------
package i2cits_pkg;

	// Transmit buffer geometry
	localparam int BUF_DEPTH = 256;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);

	// Event flag bit positions, priority lowest first
	localparam int EV_START_SENT = 0;
	localparam int EV_ADDR_SENT  = 1;
	localparam int EV_BYTE_DONE  = 2;
	localparam int EV_STOP_DET   = 3;
	localparam int EV_RX_NE      = 4;
	localparam int EV_TX_EMPTY   = 5;

	// Error flag bit positions, priority lowest first
	localparam int ER_BUS   = 0;
	localparam int ER_ARLO  = 1;
	localparam int ER_ACKF  = 2;
	localparam int ER_OVR   = 3;
	localparam int ER_PEC   = 4;
	localparam int ER_TMOUT = 5;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_EVENT = 2'd1,
		REQ_ERROR = 2'd2,
		REQ_LOAD  = 2'd3
	} req_type_t;

	typedef enum logic [3:0] {
		RUN_IDLE     = 4'd0,
		RUN_RUNNING  = 4'd1,
		RUN_FINISHED = 4'd2,
		RUN_BUS_ERR  = 4'd3,
		RUN_ARB_LOST = 4'd4,
		RUN_ACK_FAIL = 4'd5,
		RUN_OVERRUN  = 4'd6,
		RUN_PEC_ERR  = 4'd7,
		RUN_TIMEOUT  = 4'd8
	} run_state_t;

	typedef enum logic [2:0] {
		SEV_NONE    = 3'd0,
		SEV_RX_DONE = 3'd1,
		SEV_RX_DATA = 3'd2,
		SEV_TX_REQ  = 3'd3,
		SEV_TX_DONE = 3'd4
	} slave_event_t;

	// One input transaction
	typedef struct packed {
		req_type_t   req_type;
		logic [5:0]  event_flags;
		logic [5:0]  error_flags;
		logic        is_master;
		logic [7:0]  rx_byte;
		logic [6:0]  slave_address;
		logic [7:0]  transfer_len;
		logic        direction;
		logic        repeat_start;
		logic [7:0]  load_index;
		logic [7:0]  load_byte;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic         start_gen;
		logic         dr_write;
		logic [7:0]   dr_value;
		logic         ack_off;
		logic         ack_on;
		logic         stop_gen;
		logic         rx_valid;
		logic [7:0]   rx_index;
		logic [7:0]   rx_data;
		slave_event_t slave_event;
		run_state_t   run_state;
	} result_t;

	// Transfer context
	typedef struct packed {
		logic       direction;
		logic [6:0] address;
		logic [7:0] length;
		logic       repeat_start;
		logic [7:0] byte_index;
		run_state_t status;
	} xfer_state_t;

	// Map a byte position onto a buffer address
	function automatic logic [BUF_AW-1:0] buf_addr(input logic [7:0] v);
		return BUF_AW'(32'(v) % BUF_DEPTH);
	endfunction

endpackage

/* design/i2cits_txbuf.sv */
// ----------------------------------------------------------------------------
// Transmit buffer
// Single write port, single registered read port with write-to-read bypass.
// ----------------------------------------------------------------------------
module i2cits_txbuf (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [i2cits_pkg::BUF_AW-1:0] wr_addr,
	input  logic [7:0]                    wr_data,
	input  logic [i2cits_pkg::BUF_AW-1:0] rd_addr,
	output logic [7:0]                    rd_data
);

	logic [7:0] mem [i2cits_pkg::BUF_DEPTH];
	logic [7:0] rd_q;
	logic       byp_q;
	logic [7:0] byp_data_q;

	// Write the array and register the read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Hold the written byte when it lands on the address being read
	always_ff @(posedge clk) begin
		byp_q      <= wr_en && (wr_addr == rd_addr);
		byp_data_q <= wr_data;
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

/* design/i2cits_core.sv */
// ----------------------------------------------------------------------------
// Sequencer decode
// Single-pass decode of one transaction against the transfer context.
// ----------------------------------------------------------------------------
module i2cits_core (
	input  i2cits_pkg::item_t       item,
	input  i2cits_pkg::xfer_state_t st,
	input  logic [7:0]              tx_data,
	output i2cits_pkg::result_t     res,
	output i2cits_pkg::xfer_state_t st_nxt
);

	logic [8:0] idx_w;
	logic [8:0] len_w;
	logic [7:0] idx_inc;

	assign idx_w   = {1'b0, st.byte_index};
	assign len_w   = {1'b0, st.length};
	assign idx_inc = st.byte_index + 8'd1;

	always_comb begin
		res             = '0;
		res.slave_event = i2cits_pkg::SEV_NONE;
		st_nxt          = st;
		case (item.req_type)
			i2cits_pkg::REQ_START: begin
				st_nxt.direction    = item.direction;
				st_nxt.address      = item.slave_address;
				st_nxt.length       = item.transfer_len;
				st_nxt.repeat_start = item.repeat_start;
				st_nxt.byte_index   = '0;
				st_nxt.status       = i2cits_pkg::RUN_RUNNING;
				res.start_gen       = 1'b1;
			end
			i2cits_pkg::REQ_EVENT: begin
				// Lowest set event flag alone decides
				if (item.event_flags[i2cits_pkg::EV_START_SENT]) begin
					res.dr_write = 1'b1;
					res.dr_value = {st.address, st.direction};
				end else if (item.event_flags[i2cits_pkg::EV_ADDR_SENT]) begin
					res.ack_off = item.is_master && st.direction && (st.length == 8'd1);
				end else if (item.event_flags[i2cits_pkg::EV_BYTE_DONE]) begin
					if (!st.direction && (st.byte_index == st.length)) begin
						res.stop_gen  = !st.repeat_start;
						st_nxt.status = i2cits_pkg::RUN_FINISHED;
					end
				end else if (item.event_flags[i2cits_pkg::EV_STOP_DET]) begin
					res.slave_event = i2cits_pkg::SEV_RX_DONE;
				end else if (item.event_flags[i2cits_pkg::EV_RX_NE]) begin
					if (item.is_master) begin
						res.ack_off  = (st.length >= 8'd2) && (idx_w + 9'd2 == len_w);
						res.stop_gen = (st.length >= 8'd1) && (idx_w + 9'd1 == len_w)
							&& !st.repeat_start;
						// Hand out the byte unless the transfer is already complete
						if (st.byte_index < st.length) begin
							res.rx_valid      = 1'b1;
							res.rx_index      = st.byte_index;
							res.rx_data       = item.rx_byte;
							st_nxt.byte_index = idx_inc;
							if (idx_inc == st.length) begin
								st_nxt.status = i2cits_pkg::RUN_FINISHED;
								res.ack_on    = 1'b1;
							end
						end
					end else begin
						res.slave_event = i2cits_pkg::SEV_RX_DATA;
					end
				end else if (item.event_flags[i2cits_pkg::EV_TX_EMPTY]) begin
					if (item.is_master) begin
						if (st.byte_index < st.length) begin
							res.dr_write      = 1'b1;
							res.dr_value      = tx_data;
							st_nxt.byte_index = idx_inc;
						end
					end else begin
						res.slave_event = i2cits_pkg::SEV_TX_REQ;
					end
				end
			end
			i2cits_pkg::REQ_ERROR: begin
				// Lowest set error flag alone decides
				if (item.error_flags[i2cits_pkg::ER_BUS]) begin
					st_nxt.status = i2cits_pkg::RUN_BUS_ERR;
				end else if (item.error_flags[i2cits_pkg::ER_ARLO]) begin
					st_nxt.status = i2cits_pkg::RUN_ARB_LOST;
				end else if (item.error_flags[i2cits_pkg::ER_ACKF]) begin
					if (item.is_master) begin
						st_nxt.status = i2cits_pkg::RUN_ACK_FAIL;
					end else begin
						res.slave_event = i2cits_pkg::SEV_TX_DONE;
					end
				end else if (item.error_flags[i2cits_pkg::ER_OVR]) begin
					st_nxt.status = i2cits_pkg::RUN_OVERRUN;
				end else if (item.error_flags[i2cits_pkg::ER_PEC]) begin
					st_nxt.status = i2cits_pkg::RUN_PEC_ERR;
				end else if (item.error_flags[i2cits_pkg::ER_TMOUT]) begin
					st_nxt.status = i2cits_pkg::RUN_TIMEOUT;
				end
			end
			default: begin
				// Buffer loads touch only the transmit buffer
			end
		endcase
		res.run_state = st_nxt.status;
	end

endmodule

/* design/i2c_interrupt_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C interrupt transfer sequencer
// Turns start requests, event and error snapshots into bus control actions.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while results are taken,
// and returns exactly one result transaction for each, in order. A
// transaction is captured in an input register, decoded in one pass against
// the transfer context and the transmit buffer, and the result is held in an
// output register. While a result waits, one more transaction is taken into
// the input register and the input then stalls until the result is taken.
// The transmit buffer is a single-port-read memory whose read is issued ahead
// at the byte index the next transaction will see, with a bypass for a load
// to the same position, so back-to-back loads and transmit events run at
// full rate. Buffer entries are undefined until loaded; there is no clearing
// pass.
module i2c_interrupt_transfer_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [5:0] event_flags,
	input  logic [5:0] error_flags,
	input  logic       is_master,
	input  logic [7:0] rx_byte,
	input  logic [6:0] slave_address,
	input  logic [7:0] transfer_len,
	input  logic       direction,
	input  logic       repeat_start,
	input  logic [7:0] load_index,
	input  logic [7:0] load_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       start_gen,
	output logic       dr_write,
	output logic [7:0] dr_value,
	output logic       ack_off,
	output logic       ack_on,
	output logic       stop_gen,
	output logic       rx_valid,
	output logic [7:0] rx_index,
	output logic [7:0] rx_data,
	output logic [2:0] slave_event,
	output logic [3:0] run_state
);

	`include "assert_macros.svh"

	i2cits_pkg::item_t       item_in;
	i2cits_pkg::item_t       item_s1;
	logic                    valid_s1;
	i2cits_pkg::result_t     res_c;
	i2cits_pkg::result_t     res_s2;
	logic                    valid_s2;
	i2cits_pkg::xfer_state_t st_q;
	i2cits_pkg::xfer_state_t st_c;
	logic                    adv;
	logic                    accept;
	logic [7:0]              idx_nxt;
	logic [7:0]              tx_data;
	logic                    wr_en;

	// Gather the input transaction
	always_comb begin
		item_in.req_type      = i2cits_pkg::req_type_t'(req_type);
		item_in.event_flags   = event_flags;
		item_in.error_flags   = error_flags;
		item_in.is_master     = is_master;
		item_in.rx_byte       = rx_byte;
		item_in.slave_address = slave_address;
		item_in.transfer_len  = transfer_len;
		item_in.direction     = direction;
		item_in.repeat_start  = repeat_start;
		item_in.load_index    = load_index;
		item_in.load_byte     = load_byte;
	end

	// Advance the decode stage when the output register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
	end

	// Decode
	i2cits_core u_core (
		.item    (item_s1),
		.st      (st_q),
		.tx_data (tx_data),
		.res     (res_c),
		.st_nxt  (st_c)
	);

	// Transfer context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.direction    <= 1'b0;
			st_q.address      <= '0;
			st_q.length       <= '0;
			st_q.repeat_start <= 1'b0;
			st_q.byte_index   <= '0;
			st_q.status       <= i2cits_pkg::RUN_IDLE;
		end else if (adv) begin
			st_q <= st_c;
		end
	end

	// Read the buffer at the index the next transaction will see
	assign idx_nxt = adv ? st_c.byte_index : st_q.byte_index;
	assign wr_en   = adv && (item_s1.req_type == i2cits_pkg::REQ_LOAD);

	i2cits_txbuf u_txbuf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (i2cits_pkg::buf_addr(item_s1.load_index)),
		.wr_data (item_s1.load_byte),
		.rd_addr (i2cits_pkg::buf_addr(idx_nxt)),
		.rd_data (tx_data)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	// Drive the result ports
	assign out_valid   = valid_s2;
	assign start_gen   = res_s2.start_gen;
	assign dr_write    = res_s2.dr_write;
	assign dr_value    = res_s2.dr_value;
	assign ack_off     = res_s2.ack_off;
	assign ack_on      = res_s2.ack_on;
	assign stop_gen    = res_s2.stop_gen;
	assign rx_valid    = res_s2.rx_valid;
	assign rx_index    = res_s2.rx_index;
	assign rx_data     = res_s2.rx_data;
	assign slave_event = res_s2.slave_event;
	assign run_state   = res_s2.run_state;

	// The byte index never runs past the transfer length
	`ASSERT_ALWAYS(a_idx_bound, st_q.byte_index <= st_q.length)

	// An empty decode stage always takes a new transaction
	`ASSERT_ALWAYS(a_ready_empty, valid_s1 || in_ready)

	// A start request restarts the transfer context
	`ASSERT_NEXT(a_start_ctx, adv && (item_s1.req_type == i2cits_pkg::REQ_START),
		(st_q.status == i2cits_pkg::RUN_RUNNING) && (st_q.byte_index == 8'd0))

	// Each decoded transaction lands in the result register
	`ASSERT_NEXT(a_adv_out, adv, valid_s2 && (res_s2.run_state == st_q.status))

endmodule
